@@ hw/rtl/jfs_pkg.sv @@
// Shared types, codes and helpers for the JPEG frame size scanner.
package jfs_pkg;

  localparam int DataW   = 8;
  localparam int DimW    = 16;
  localparam int StatusW = 3;
  localparam int SkipW   = 16;
  localparam int IdxW    = 3;
  localparam int OutTdataW = 40;

  localparam logic [DataW-1:0] MRK_FILL = 8'hFF;
  localparam logic [DataW-1:0] MRK_SOI  = 8'hD8;
  localparam logic [DataW-1:0] MRK_EOI  = 8'hD9;
  localparam logic [DataW-1:0] MRK_SOS  = 8'hDA;

  localparam logic [StatusW-1:0] STAT_FOUND     = 3'd0;
  localparam logic [StatusW-1:0] STAT_NO_START  = 3'd1;
  localparam logic [StatusW-1:0] STAT_SCAN_END  = 3'd2;
  localparam logic [StatusW-1:0] STAT_TRUNCATED = 3'd3;
  localparam logic [StatusW-1:0] STAT_SHORT_SEG = 3'd4;
  localparam logic [StatusW-1:0] STAT_ZERO_SIZE = 3'd5;

  localparam logic [IdxW-1:0] FIDX_HGT_HI = 3'd1;
  localparam logic [IdxW-1:0] FIDX_HGT_LO = 3'd2;
  localparam logic [IdxW-1:0] FIDX_WID_HI = 3'd3;
  localparam logic [IdxW-1:0] FIDX_WID_LO = 3'd4;

  typedef enum logic [8:0] {
    PH_START0 = 9'b000000001,
    PH_START1 = 9'b000000010,
    PH_MARK0  = 9'b000000100,
    PH_MARK1  = 9'b000001000,
    PH_LEN_HI = 9'b000010000,
    PH_LEN_LO = 9'b000100000,
    PH_FRAME  = 9'b001000000,
    PH_SKIP   = 9'b010000000,
    PH_DONE   = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [DimW-1:0]    image_height;
    logic [DimW-1:0]    image_width;
    logic [StatusW-1:0] status;
  } result_t;

  typedef struct packed {
    logic    have;
    result_t res;
  } result_req_t;

  function automatic logic is_frame_type(input logic [DataW-1:0] t);
    logic r;
    begin
      case (t) inside
        [8'hC0:8'hC3], [8'hC5:8'hC7], [8'hC9:8'hCB], [8'hCD:8'hCF]: r = 1'b1;
        default: r = 1'b0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ hw/rtl/jfs_parser.sv @@
// Marker segment walker: parse state and per-byte result decision.
module jfs_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [jfs_pkg::DataW-1:0]    data_byte,
  input  logic                         last_byte,
  output jfs_pkg::result_req_t         req
);

  jfs_pkg::phase_t               phase_r, phase_nxt;
  logic [jfs_pkg::DataW-1:0]     held_r, held_nxt;
  logic [jfs_pkg::DataW-1:0]     seg_type_r, seg_type_nxt;
  logic [jfs_pkg::DataW-1:0]     len_hi_r, len_hi_nxt;
  logic [jfs_pkg::SkipW-1:0]     skip_r, skip_nxt;
  logic [jfs_pkg::IdxW-1:0]      fidx_r, fidx_nxt;
  logic [jfs_pkg::DimW-1:0]      hgt_r, hgt_nxt;
  logic [jfs_pkg::DataW-1:0]     wid_hi_r, wid_hi_nxt;
  logic [jfs_pkg::SkipW-1:0]     seg_len;
  logic [jfs_pkg::DimW-1:0]      frame_w;
  logic                          have;
  logic [jfs_pkg::StatusW-1:0]   st;
  logic [jfs_pkg::DimW-1:0]      w_out, h_out;

  assign seg_len = {len_hi_r, data_byte};
  assign frame_w = {wid_hi_r, data_byte};

  always_comb begin
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    seg_type_nxt = seg_type_r;
    len_hi_nxt   = len_hi_r;
    skip_nxt     = skip_r;
    fidx_nxt     = fidx_r;
    hgt_nxt      = hgt_r;
    wid_hi_nxt   = wid_hi_r;
    have         = 1'b0;
    st           = jfs_pkg::STAT_FOUND;
    w_out        = '0;
    h_out        = '0;

    unique case (phase_r)
      jfs_pkg::PH_START0: begin
        if (data_byte == jfs_pkg::MRK_FILL) begin
          phase_nxt = jfs_pkg::PH_START1;
        end else begin
          have = 1'b1; st = jfs_pkg::STAT_NO_START; phase_nxt = jfs_pkg::PH_DONE;
        end
      end
      jfs_pkg::PH_START1: begin
        if (data_byte == jfs_pkg::MRK_SOI) begin
          phase_nxt = jfs_pkg::PH_MARK0;
        end else begin
          have = 1'b1; st = jfs_pkg::STAT_NO_START; phase_nxt = jfs_pkg::PH_DONE;
        end
      end
      jfs_pkg::PH_MARK0: begin
        held_nxt  = data_byte;
        phase_nxt = jfs_pkg::PH_MARK1;
      end
      jfs_pkg::PH_MARK1: begin
        if (held_r != jfs_pkg::MRK_FILL) begin
          held_nxt = data_byte;
        end else begin
          seg_type_nxt = data_byte;
          if (data_byte == jfs_pkg::MRK_EOI || data_byte == jfs_pkg::MRK_SOS) begin
            have = 1'b1; st = jfs_pkg::STAT_SCAN_END; phase_nxt = jfs_pkg::PH_DONE;
          end else begin
            phase_nxt = jfs_pkg::PH_LEN_HI;
          end
        end
      end
      jfs_pkg::PH_LEN_HI: begin
        len_hi_nxt = data_byte;
        phase_nxt  = jfs_pkg::PH_LEN_LO;
      end
      jfs_pkg::PH_LEN_LO: begin
        if (seg_len < jfs_pkg::SkipW'(2)) begin
          have = 1'b1; st = jfs_pkg::STAT_SHORT_SEG; phase_nxt = jfs_pkg::PH_DONE;
        end else if (jfs_pkg::is_frame_type(seg_type_r)) begin
          fidx_nxt  = '0;
          phase_nxt = jfs_pkg::PH_FRAME;
        end else begin
          skip_nxt  = seg_len - jfs_pkg::SkipW'(2);
          phase_nxt = (seg_len == jfs_pkg::SkipW'(2)) ? jfs_pkg::PH_MARK0
                                                      : jfs_pkg::PH_SKIP;
        end
      end
      jfs_pkg::PH_FRAME: begin
        fidx_nxt = fidx_r + jfs_pkg::IdxW'(1);
        case (fidx_r)
          jfs_pkg::FIDX_HGT_HI: hgt_nxt    = {data_byte, 8'h00};
          jfs_pkg::FIDX_HGT_LO: hgt_nxt    = {hgt_r[15:8], data_byte};
          jfs_pkg::FIDX_WID_HI: wid_hi_nxt = data_byte;
          jfs_pkg::FIDX_WID_LO: begin
            have      = 1'b1;
            phase_nxt = jfs_pkg::PH_DONE;
            if (frame_w != '0 && hgt_r != '0) begin
              st = jfs_pkg::STAT_FOUND; w_out = frame_w; h_out = hgt_r;
            end else begin
              st = jfs_pkg::STAT_ZERO_SIZE;
            end
          end
          default: ;
        endcase
      end
      jfs_pkg::PH_SKIP: begin
        skip_nxt = skip_r - jfs_pkg::SkipW'(1);
        if (skip_r == jfs_pkg::SkipW'(1)) begin
          phase_nxt = jfs_pkg::PH_MARK0;
        end
      end
      default: begin
        phase_nxt = jfs_pkg::PH_DONE;
      end
    endcase

    if (last_byte) begin
      if (!have && phase_r != jfs_pkg::PH_DONE) begin
        have  = 1'b1;
        st    = (phase_nxt == jfs_pkg::PH_START0 || phase_nxt == jfs_pkg::PH_START1) ?
                jfs_pkg::STAT_NO_START : jfs_pkg::STAT_TRUNCATED;
        w_out = '0;
        h_out = '0;
      end
      phase_nxt    = jfs_pkg::PH_START0;
      held_nxt     = '0;
      seg_type_nxt = '0;
      len_hi_nxt   = '0;
      skip_nxt     = '0;
      fidx_nxt     = '0;
      hgt_nxt      = '0;
      wid_hi_nxt   = '0;
    end
  end

  assign req.have             = have;
  assign req.res.status       = st;
  assign req.res.image_width  = w_out;
  assign req.res.image_height = h_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= jfs_pkg::PH_START0;
      held_r     <= '0;
      seg_type_r <= '0;
      len_hi_r   <= '0;
      skip_r     <= '0;
      fidx_r     <= '0;
      hgt_r      <= '0;
      wid_hi_r   <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      held_r     <= held_nxt;
      seg_type_r <= seg_type_nxt;
      len_hi_r   <= len_hi_nxt;
      skip_r     <= skip_nxt;
      fidx_r     <= fidx_nxt;
      hgt_r      <= hgt_nxt;
      wid_hi_r   <= wid_hi_nxt;
    end
  end

endmodule

@@ hw/rtl/jfs_out_buf.sv @@
// Result output register with a skid stage.
module jfs_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  jfs_pkg::result_t     push_res,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output jfs_pkg::result_t     out_res
);

  logic             main_vld_r;
  logic             skid_vld_r;
  jfs_pkg::result_t main_r;
  jfs_pkg::result_t skid_r;

  assign push_ready = !skid_vld_r;
  assign out_valid  = main_vld_r;
  assign out_res    = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (main_vld_r && out_ready) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        main_vld_r <= push;
      end
    end else if (!main_vld_r) begin
      main_vld_r <= push;
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_vld_r && out_ready) begin
      main_r <= skid_vld_r ? skid_r : push_res;
    end else if (!main_vld_r) begin
      main_r <= push_res;
    end
    if (main_vld_r && !out_ready && push) begin
      skid_r <= push_res;
    end
  end

endmodule

@@ hw/rtl/jpeg_frame_size_scanner.sv @@
// Top level of the JPEG frame size scanner.
//
// Input stream: one file byte per request on in_tdata, in_tlast on the
// final byte of the file. The block checks the FF D8 start marker, walks
// the marker segments and reports the frame size at the first
// start-of-frame segment, or a status code when the search ends early.
// Each file yields exactly one result request on the output stream.
// Output tdata: status (0 found, 1 no start marker, 2 scan/end marker,
// 3 truncated, 4 short segment, 5 zero size), width, height.
// Throughput: one byte per cycle while in_tready is high; every byte is handled
// by the parse state update. A result is registered into the output register,
// or into the skid entry while the output register is stalled.
// Bytes after a result are dropped until in_tlast, which restarts the parser.
// Reset: parser waits for the first start byte, output stream empty.
// Stall: the output register plus one skid entry hold results; in_tready
// drops only while the skid entry is occupied.
module jpeg_frame_size_scanner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tlast,   // last_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [2:0] status, [18:3] image_width, [34:19] image_height, [39:35] zero
  output logic [jfs_pkg::OutTdataW-1:0]  out_tdata
);

  logic                 in_acc;
  jfs_pkg::result_req_t req;
  jfs_pkg::result_t     out_res;

  assign in_acc = in_tvalid && in_tready;

  jfs_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .req       (req)
  );

  jfs_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_acc && req.have),
    .push_res   (req.res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {5'b0, out_res};

endmodule

@@ hw/rtl/jfs_checker.sv @@
// Port-level checks for the JPEG frame size scanner, bound to the top level.
module jfs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [jfs_pkg::OutTdataW-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output request changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= jfs_pkg::STAT_ZERO_SIZE && out_tdata[39:35] == '0)
    else $error("bad status code or padding");

  a_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != jfs_pkg::STAT_FOUND |-> out_tdata[34:3] == '0)
    else $error("size reported with non-found status");

  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == jfs_pkg::STAT_FOUND |->
      out_tdata[18:3] != '0 && out_tdata[34:19] != '0)
    else $error("found status with zero dimension");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output not empty after reset");

endmodule

bind jpeg_frame_size_scanner jfs_checker u_jfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/sv/jfs_size_checker.sv @@
`timescale 1ns / 1ps
// Frame size checker: tracks the scanner state from accepted bytes and checks each result request.
module jfs_size_checker
  import jfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tlast,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [OutTdataW-1:0] out_tdata,
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen,
  output int                   sizes_found
);

  phase_t      phase;
  logic [7:0]  mark_hold;
  logic [7:0]  seg_kind;
  logic [7:0]  len_msb;
  logic [7:0]  cols_msb;
  logic [15:0] body_left;
  logic [15:0] rows;
  logic [2:0]  sof_idx;
  result_t     size_q[$];
  int          fails;
  int          seen;
  int          found;

  // C4, C8 and CC share the C nibble but are not frame headers
  function automatic logic sof_marker(input logic [7:0] t);
    return t[7:4] == 4'hC && (t[1:0] != 2'b00 || t[3:2] == 2'b00);
  endfunction

  task automatic clear_scan();
    phase     = PH_START0;
    mark_hold = '0;
    seg_kind  = '0;
    len_msb   = '0;
    cols_msb  = '0;
    body_left = '0;
    rows      = '0;
    sof_idx   = '0;
  endtask

  task automatic report(input string what);
    $display("%0t: check failed: %s", $time, what);
    fails++;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic fin);
    result_t     r;
    logic        hit;
    logic        was_done;
    logic [15:0] seg_len;
    logic [15:0] cols;
    r        = '0;
    hit      = 1'b0;
    was_done = (phase == PH_DONE);
    case (phase)
      PH_START0: begin
        if (b == MRK_FILL) begin
          phase = PH_START1;
        end else begin
          hit = 1'b1; r.status = STAT_NO_START; phase = PH_DONE;
        end
      end
      PH_START1: begin
        if (b == MRK_SOI) begin
          phase = PH_MARK0;
        end else begin
          hit = 1'b1; r.status = STAT_NO_START; phase = PH_DONE;
        end
      end
      PH_MARK0: begin
        mark_hold = b;
        phase     = PH_MARK1;
      end
      PH_MARK1: begin
        if (mark_hold != MRK_FILL) begin
          mark_hold = b;
        end else begin
          seg_kind = b;
          if (b == MRK_EOI || b == MRK_SOS) begin
            hit = 1'b1; r.status = STAT_SCAN_END; phase = PH_DONE;
          end else begin
            phase = PH_LEN_HI;
          end
        end
      end
      PH_LEN_HI: begin
        len_msb = b;
        phase   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        seg_len = {len_msb, b};
        if (seg_len < 16'd2) begin
          hit = 1'b1; r.status = STAT_SHORT_SEG; phase = PH_DONE;
        end else if (sof_marker(seg_kind)) begin
          sof_idx = '0;
          phase   = PH_FRAME;
        end else begin
          body_left = seg_len - 16'd2;
          phase     = (body_left == '0) ? PH_MARK0 : PH_SKIP;
        end
      end
      PH_FRAME: begin
        case (sof_idx)
          FIDX_HGT_HI: rows = {b, 8'h00};
          FIDX_HGT_LO: rows = rows | {8'h00, b};
          FIDX_WID_HI: cols_msb = b;
          FIDX_WID_LO: begin
            cols  = {cols_msb, b};
            hit   = 1'b1;
            phase = PH_DONE;
            if (cols != '0 && rows != '0) begin
              r.status       = STAT_FOUND;
              r.image_width  = cols;
              r.image_height = rows;
            end else begin
              r.status = STAT_ZERO_SIZE;
            end
          end
          default: ;
        endcase
        sof_idx = sof_idx + 3'd1;
      end
      PH_SKIP: begin
        body_left = body_left - 16'd1;
        if (body_left == '0) phase = PH_MARK0;
      end
      default: phase = PH_DONE;
    endcase

    if (fin) begin
      if (!hit && !was_done) begin
        hit = 1'b1;
        r   = '0;
        r.status = (phase == PH_START0 || phase == PH_START1) ? STAT_NO_START
                                                              : STAT_TRUNCATED;
      end
      clear_scan();
    end

    if (hit) size_q.push_back(r);
  endtask

  task automatic take_result(input result_t got);
    result_t want;
    seen++;
    if (size_q.size() == 0) begin
      report($sformatf("unexpected result status %0d width %0d height %0d",
                       got.status, got.image_width, got.image_height));
      return;
    end
    want = size_q.pop_front();
    if (got.status != want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.image_width != want.image_width)
      report($sformatf("width %0d, want %0d", got.image_width, want.image_width));
    if (got.image_height != want.image_height)
      report($sformatf("height %0d, want %0d", got.image_height, want.image_height));
    if (got.status == STAT_FOUND) found++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      size_q.delete();
    end else begin
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) take_result(out_tdata[$bits(result_t)-1:0]);
    end
    fail_count   <= fails;
    pending      <= size_q.size();
    results_seen <= seen;
    sizes_found  <= found;
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the JPEG frame size scanner: clock, reset, file byte stimulus and verdict.
module tb;
  import jfs_pkg::*;

  localparam int StallLimit    = 2000;
  localparam int SqueezeCycles = 150;
  localparam int RandomBytes   = 550;

  localparam logic [7:0] MRK_APP0 = 8'hE0;
  localparam logic [7:0] MRK_RST0 = 8'hD0;
  localparam logic [7:0] MRK_DHT  = 8'hC4;
  localparam logic [7:0] MRK_JPG  = 8'hC8;
  localparam logic [7:0] MRK_DAC  = 8'hCC;
  localparam logic [7:0] MRK_DQT  = 8'hDB;
  localparam logic [7:0] MRK_COM  = 8'hFE;
  localparam logic [7:0] SOF_CODES [0:12] = '{
    8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC5, 8'hC6, 8'hC7,
    8'hC9, 8'hCA, 8'hCB, 8'hCD, 8'hCE, 8'hCF
  };

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutTdataW-1:0] out_tdata;

  int fail_count;
  int pending;
  int results_seen;
  int sizes_found;
  int bytes_sent  = 0;
  int files_sent  = 0;
  int idle_cycles = 0;
  bit calm        = 1'b0;
  bit squeeze_go  = 1'b0;
  bit squeezed    = 1'b0;
  bit rx_holding  = 1'b0;

  logic [7:0] file_q[$];

  jpeg_frame_size_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  jfs_size_checker size_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .sizes_found  (sizes_found)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("watchdog: no request accepted for %0d cycles", StallLimit);
      $display("jpeg_frame_size_scanner: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall bursts, one long hold-off to back up the input
  initial begin
    int n;
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze_go && !squeezed) begin
        squeezed   = 1'b1;
        rx_holding = 1'b1;
        out_tready <= 1'b0;
        repeat (SqueezeCycles) @(posedge clk);
        rx_holding = 1'b0;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        n = calm ? 1 : $urandom_range(1, 18);
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    in_tdata  <= b;
    in_tlast  <= fin;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    if (!calm && !rx_holding && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    files_sent++;
  endtask

  function automatic logic [7:0] other_kind();
    case ($urandom_range(0, 6))
      0: return MRK_APP0 | 8'($urandom_range(0, 15));
      1: return MRK_RST0 | 8'($urandom_range(0, 7));
      2: return MRK_DHT;
      3: return MRK_JPG;
      4: return MRK_DAC;
      5: return MRK_DQT;
      default: return $urandom_range(0, 1) ? MRK_COM : MRK_FILL;
    endcase
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      3: return 16'($urandom_range(1, 255));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic add_segment(input logic [7:0] kind, input int body);
    logic [15:0] len;
    len = 16'(body + 2);
    file_q.push_back(MRK_FILL);
    file_q.push_back(kind);
    file_q.push_back(len[15:8]);
    file_q.push_back(len[7:0]);
    repeat (body) file_q.push_back(8'($urandom));
  endtask

  task automatic add_frame(input bit short_len);
    logic [15:0] h;
    logic [15:0] w;
    h = pick_dim();
    w = pick_dim();
    file_q.push_back(MRK_FILL);
    file_q.push_back(SOF_CODES[$urandom_range(0, 12)]);
    file_q.push_back(8'h00);
    file_q.push_back(short_len ? 8'($urandom_range(2, 6)) : 8'h11);
    file_q.push_back(8'h08);
    file_q.push_back(h[15:8]);
    file_q.push_back(h[7:0]);
    file_q.push_back(w[15:8]);
    file_q.push_back(w[7:0]);
  endtask

  task automatic build_jpeg();
    int pick;
    int cut;
    file_q.delete();
    file_q.push_back(MRK_FILL);
    file_q.push_back(MRK_SOI);
    repeat ($urandom_range(0, 3)) begin
      // junk before a marker forces a resync
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) file_q.push_back(8'($urandom_range(0, 254)));
      add_segment(other_kind(),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6));
    end
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      add_frame(1'b0);
    end else if (pick == 6) begin
      add_frame(1'b1);
    end else if (pick == 7) begin
      file_q.push_back(MRK_FILL);
      file_q.push_back($urandom_range(0, 1) ? MRK_EOI : MRK_SOS);
    end else if (pick == 8) begin
      file_q.push_back(MRK_FILL);
      file_q.push_back($urandom_range(0, 1) ? SOF_CODES[$urandom_range(0, 12)] : other_kind());
      file_q.push_back(8'h00);
      file_q.push_back(8'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endtask

  task automatic build_noise();
    file_q.delete();
    repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom));
    if ($urandom_range(0, 1) == 0) file_q[0] = MRK_FILL;
  endtask

  initial begin
    int rand_start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    file_q = '{8'h00};
    send_file();
    file_q = '{MRK_FILL};
    send_file();
    file_q = '{MRK_FILL, 8'h12, 8'hAA};
    send_file();
    file_q = '{MRK_FILL, MRK_SOI, MRK_FILL, MRK_SOS};
    send_file();
    file_q = '{MRK_FILL, MRK_SOI, MRK_FILL};
    send_file();
    // junk, fill byte taken as type, then a zero length
    file_q = '{MRK_FILL, MRK_SOI, 8'h12, MRK_FILL, MRK_FILL, 8'h00, 8'h02,
               MRK_FILL, MRK_APP0, 8'h00, 8'h00};
    send_file();
    // frame segment with a too-short length still yields its size
    file_q = '{MRK_FILL, MRK_SOI, MRK_FILL, SOF_CODES[0], 8'h00, 8'h02, 8'h08,
               8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_file();
    file_q = '{MRK_FILL, MRK_SOI, MRK_FILL, SOF_CODES[12], 8'h00, 8'h11, 8'h08,
               8'h00, 8'h00, 8'h00, 8'h01};
    send_file();

    rand_start = bytes_sent;
    squeeze_go = 1'b1;
    while (bytes_sent - rand_start < RandomBytes || files_sent < 40) begin
      calm = (bytes_sent - rand_start >= RandomBytes - 70);
      if ($urandom_range(0, 3) == 0) build_noise();
      else build_jpeg();
      send_file();
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d files in %0d bytes; %0d results checked, %0d with a frame size",
             files_sent, bytes_sent, results_seen, sizes_found);
    $display("result side held off for %0d cycles once while bytes kept coming",
             SqueezeCycles);
    if (fail_count == 0) begin
      $display("jpeg_frame_size_scanner: match");
    end else begin
      $display("jpeg_frame_size_scanner: mismatch");
    end
    $finish;
  end

endmodule
